[design/mhpq_pkg.sv]
// ============================================================================
// mhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int KEY_IN_W = 32;
    localparam int COUNT_W  = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_FIN,
        S_DN_LOAD,
        S_DN_CH,
        S_DN_KEY,
        S_DN_FIN,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

[design/mhpq_ram.sv]
// ============================================================================
// mhpq_ram
// Heap key store: one write port, two registered read ports.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_wen,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr0,
    input  wire logic [AW-1:0]    i_raddr1,
    output logic      [WIDTH-1:0] o_rdata0,
    output logic      [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

`default_nettype wire

[design/mhpq_seq.sv]
// ============================================================================
// mhpq_seq
// Sift sequencer: walks the heap one level at a time through a single
// shared signed comparator, moving a hole instead of swapping entries.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mhpq_seq #(
    parameter int DEPTH = 64,
    parameter int KW    = 32,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_op,
    input  wire logic [KW-1:0]     i_key,
    output logic                   o_ready,
    input  wire logic              i_resp_free,
    output logic                   o_done,
    output logic      [KW-1:0]     o_max,
    output mhpq_pkg::t_status      o_status,
    output logic      [CW-1:0]     o_count,
    output logic                   o_wen,
    output logic      [AW-1:0]     o_waddr,
    output logic      [KW-1:0]     o_wdata,
    output logic      [AW-1:0]     o_raddr0,
    output logic      [AW-1:0]     o_raddr1,
    input  wire logic [KW-1:0]     i_rdata0,
    input  wire logic [KW-1:0]     i_rdata1
);

    import mhpq_pkg::*;

    localparam int IW = AW + 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_cidx, n_cidx;
    logic [KW-1:0]   r_key, n_key;
    logic [KW-1:0]   r_child, n_child;
    logic [KW-1:0]   r_max, n_max;
    t_status         r_status, n_status;

    logic [KW-1:0]   cmp_a, cmp_b;
    logic            cmp_gt;
    logic            full, empty;
    logic [IW-1:0]   lft, rgt, nxt_l, n_iw;
    logic [AW-1:0]   par, acc_par;

    // shared comparator
    always_comb begin
        cmp_a = r_key;
        cmp_b = i_rdata0;
        case (r_state)
            S_DN_CH: begin
                cmp_a = i_rdata1;
                cmp_b = i_rdata0;
            end
            S_DN_KEY: begin
                cmp_a = r_child;
                cmp_b = r_key;
            end
            default: begin
                cmp_a = r_key;
                cmp_b = i_rdata0;
            end
        endcase
    end

    assign cmp_gt  = $signed(cmp_a) > $signed(cmp_b);
    assign full    = r_cnt == CW'(DEPTH);
    assign empty   = r_cnt == '0;
    assign lft     = {r_idx, 1'b1};
    assign rgt     = lft + IW'(1);
    assign nxt_l   = {r_cidx, 1'b1};
    assign n_iw    = IW'(r_cnt);
    assign par     = AW'((r_idx - 1'b1) >> 1);
    assign acc_par = AW'((r_cnt - 1'b1) >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_INSERT) begin
                        n_state = full ? S_RESP : (empty ? S_UP_FIN : S_UP_CMP);
                    end else begin
                        n_state = empty ? S_RESP : S_DN_LOAD;
                    end
                end
            end
            S_UP_CMP: begin
                if (cmp_gt) begin
                    n_state = (par == '0) ? S_UP_FIN : S_UP_CMP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UP_FIN:  n_state = S_RESP;
            S_DN_LOAD: begin
                if (empty) begin
                    n_state = S_RESP;
                end else begin
                    n_state = (IW'(1) < n_iw) ? S_DN_CH : S_DN_FIN;
                end
            end
            S_DN_CH:   n_state = S_DN_KEY;
            S_DN_KEY: begin
                if (cmp_gt) begin
                    n_state = (nxt_l < n_iw) ? S_DN_CH : S_DN_FIN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DN_FIN:  n_state = S_RESP;
            S_RESP:    n_state = i_resp_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_key    = r_key;
        n_child  = r_child;
        n_max    = r_max;
        n_status = r_status;
        o_wen    = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = r_key;
        o_raddr0 = par;
        o_raddr1 = AW'(rgt);
        o_ready  = r_state == S_IDLE;
        o_done   = (r_state == S_RESP) && i_resp_free;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_max = '0;
                    n_key = i_key;
                    if (i_op == OP_INSERT) begin
                        if (full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status = STAT_OK;
                            n_cnt    = r_cnt + 1'b1;
                            n_idx    = AW'(r_cnt);
                            o_raddr0 = acc_par;
                        end
                    end else begin
                        if (empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_status = STAT_OK;
                            n_cnt    = r_cnt - 1'b1;
                            o_raddr0 = '0;
                            o_raddr1 = AW'(r_cnt - 1'b1);
                        end
                    end
                end
            end
            S_UP_CMP: begin
                o_wen = 1'b1;
                if (cmp_gt) begin
                    o_wdata  = i_rdata0;
                    n_idx    = par;
                    o_raddr0 = AW'((par - 1'b1) >> 1);
                end
            end
            S_UP_FIN, S_DN_FIN: begin
                o_wen = 1'b1;
            end
            S_DN_LOAD: begin
                n_max    = i_rdata0;
                n_key    = i_rdata1;
                n_idx    = '0;
                o_raddr0 = AW'(1);
                o_raddr1 = AW'(2);
            end
            S_DN_CH: begin
                if ((rgt < n_iw) && cmp_gt) begin
                    n_child = i_rdata1;
                    n_cidx  = AW'(rgt);
                end else begin
                    n_child = i_rdata0;
                    n_cidx  = AW'(lft);
                end
            end
            S_DN_KEY: begin
                o_wen = 1'b1;
                if (cmp_gt) begin
                    o_wdata  = r_child;
                    n_idx    = r_cidx;
                    o_raddr0 = AW'(nxt_l);
                    o_raddr1 = AW'(nxt_l + IW'(1));
                end
            end
            default: begin
                o_wen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cidx   <= n_cidx;
        r_key    <= n_key;
        r_child  <= n_child;
        r_max    <= n_max;
        r_status <= n_status;
    end

    assign o_max    = r_max;
    assign o_status = r_status;
    assign o_count  = r_cnt;

endmodule

`default_nettype wire

[design/max_heap_priority_queue.sv]
// ============================================================================
// max_heap_priority_queue
// Binary max-heap priority queue with insert and remove-max requests.
// ============================================================================
// Ordering: one request at a time; a sift compares at most log2(HEAP_DEPTH)
//   levels, and refused requests go straight to the response state.
// Handshake: o_ready returns in the same cycle that o_valid rises; a held
//   result keeps the sequencer in its response state.
// Reset: synchronous, clears the entry count and control; the key store is
//   not cleared.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = 64,
    parameter int KEY_WIDTH  = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_op,
    input  wire logic signed [mhpq_pkg::KEY_IN_W-1:0] i_key,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed      [mhpq_pkg::KEY_IN_W-1:0] o_max_value,
    output mhpq_pkg::t_status                         o_status,
    output logic             [mhpq_pkg::COUNT_W-1:0]  o_count
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic                 seq_start;
    logic                 seq_done;
    logic                 resp_free;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] seq_max;
    t_status              seq_status;
    logic [CW-1:0]        seq_count;
    logic                 ram_wen;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr0, ram_raddr1;
    logic [KEY_WIDTH-1:0] ram_rdata0, ram_rdata1;

    logic                       r_valid;
    logic signed [KEY_IN_W-1:0] r_max_value;
    t_status                    r_status;
    logic [COUNT_W-1:0]         r_count;

    assign key_in    = KEY_WIDTH'(i_key);
    assign seq_start = i_valid && o_ready;
    assign resp_free = !r_valid || i_ready;

    mhpq_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH (KEY_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wen    (ram_wen),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    mhpq_seq #(
        .DEPTH (HEAP_DEPTH),
        .KW    (KEY_WIDTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (seq_start),
        .i_op        (i_op),
        .i_key       (key_in),
        .o_ready     (o_ready),
        .i_resp_free (resp_free),
        .o_done      (seq_done),
        .o_max       (seq_max),
        .o_status    (seq_status),
        .o_count     (seq_count),
        .o_wen       (ram_wen),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr0    (ram_raddr0),
        .o_raddr1    (ram_raddr1),
        .i_rdata0    (ram_rdata0),
        .i_rdata1    (ram_rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (seq_done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_max_value <= KEY_IN_W'($signed(seq_max));
            r_status    <= seq_status;
            r_count     <= COUNT_W'(seq_count);
        end
    end

    assign o_valid     = r_valid;
    assign o_max_value = r_max_value;
    assign o_status    = r_status;
    assign o_count     = r_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted item did not make the block busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_count <= CW'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FULL) |-> (o_count == COUNT_W'(HEAP_DEPTH)))
        else $error("full status with heap not full");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_max_value == '0))
        else $error("refused request returned a nonzero value");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_count == '0))
        else $error("empty status with keys held");

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: max_heap_priority_queue testbench
// Drives insert and remove-max requests through the valid/ready request
// channel and checks every result against a shadow max-heap kept in the
// testbench, or against the value of a typed directed row. A short table of
// directed requests comes first: empty handling, key extremes and equal keys.
// Random fill, drain, mix phases follow, with idle bursts until the last two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import mhpq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int WDOG_LIMIT = 2000;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 95;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic signed [KEY_IN_W-1:0] max_value;
        t_status                    status;
        logic        [COUNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic                       op;
        logic signed [KEY_IN_W-1:0] key;
        logic                       typed;
        t_result                    res;
    } t_directed_row;

    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{OP_REMOVE, 32'sd0,          1'b1, '{32'sd0,          STAT_EMPTY, 7'd0}},
        '{OP_INSERT, 32'sh7FFF_FFFF,  1'b1, '{32'sd0,          STAT_OK,    7'd1}},
        '{OP_INSERT, 32'sh8000_0000,  1'b1, '{32'sd0,          STAT_OK,    7'd2}},
        '{OP_INSERT, 32'sd0,          1'b1, '{32'sd0,          STAT_OK,    7'd3}},
        '{OP_INSERT, -32'sd1,         1'b1, '{32'sd0,          STAT_OK,    7'd4}},
        '{OP_INSERT, 32'sd1,          1'b1, '{32'sd0,          STAT_OK,    7'd5}},
        '{OP_REMOVE, 32'sd0,          1'b1, '{32'sh7FFF_FFFF,  STAT_OK,    7'd4}},
        '{OP_REMOVE, 32'sd0,          1'b1, '{32'sd1,          STAT_OK,    7'd3}},
        '{OP_REMOVE, 32'sd0,          1'b1, '{32'sd0,          STAT_OK,    7'd2}},
        '{OP_REMOVE, 32'sd0,          1'b1, '{-32'sd1,         STAT_OK,    7'd1}},
        '{OP_REMOVE, 32'sd0,          1'b1, '{32'sh8000_0000,  STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sh7FFF_FFFF,  1'b1, '{32'sd0,          STAT_EMPTY, 7'd0}},
        '{OP_INSERT, 32'sd5,          1'b1, '{32'sd0,          STAT_OK,    7'd1}},
        '{OP_INSERT, 32'sd5,          1'b1, '{32'sd0,          STAT_OK,    7'd2}},
        '{OP_INSERT, 32'sh5555_5555,  1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_INSERT, 32'sd5,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_INSERT, 32'shAAAA_AAAA,  1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, -32'sd1,         1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_INSERT, -32'sd7,         1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}},
        '{OP_REMOVE, 32'sd0,          1'b0, '{32'sd0,          STAT_OK,    7'd0}}
    };

    // insert percentage per random phase: fill, drain, mix
    localparam int INSERT_PCT [N_PHASES] = '{95, 5, 50, 95, 60, 5, 40, 95, 5, 50};

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        i_op    = OP_INSERT;
    logic signed [KEY_IN_W-1:0]  i_key   = '0;
    logic                        i_ready = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic signed [KEY_IN_W-1:0]  o_max_value;
    t_status                     o_status;
    logic        [COUNT_W-1:0]   o_count;

    logic signed [KEY_IN_W-1:0]  shadow_heap [DEPTH];
    int unsigned                 shadow_count = 0;
    t_result                     pending_results [$];

    bit          quiet = 1'b0;
    int unsigned n_errors = 0;
    int unsigned n_checked = 0;
    int unsigned n_inserts = 0;
    int unsigned n_removes = 0;
    int unsigned n_full = 0;
    int unsigned n_empty = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    max_heap_priority_queue #(
        .HEAP_DEPTH (DEPTH),
        .KEY_WIDTH  (KEY_IN_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_max_value (o_max_value),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result heap_apply(logic op, logic signed [KEY_IN_W-1:0] key);
        t_result                    res;
        int unsigned                idx;
        int unsigned                par;
        int unsigned                lft;
        int unsigned                rgt;
        int unsigned                big;
        logic signed [KEY_IN_W-1:0] tmp;
        res = '{max_value: '0, status: STAT_OK, count: '0};
        if (op == OP_INSERT) begin
            n_inserts++;
            if (shadow_count >= DEPTH) begin
                res.status = STAT_FULL;
                n_full++;
            end else begin
                idx = shadow_count;
                shadow_heap[idx] = key;
                while (idx > 0) begin
                    par = (idx - 1) / 2;
                    if (shadow_heap[par] < shadow_heap[idx]) begin
                        tmp = shadow_heap[par];
                        shadow_heap[par] = shadow_heap[idx];
                        shadow_heap[idx] = tmp;
                        idx = par;
                    end else begin
                        break;
                    end
                end
                shadow_count++;
            end
        end else begin
            n_removes++;
            if (shadow_count == 0) begin
                res.status = STAT_EMPTY;
                n_empty++;
            end else begin
                res.max_value = shadow_heap[0];
                shadow_count--;
                shadow_heap[0] = shadow_heap[shadow_count];
                idx = 0;
                forever begin
                    lft = 2 * idx + 1;
                    rgt = lft + 1;
                    if (lft >= shadow_count) break;
                    big = lft;
                    if (rgt < shadow_count && shadow_heap[rgt] > shadow_heap[lft]) big = rgt;
                    if (shadow_heap[big] > shadow_heap[idx]) begin
                        tmp = shadow_heap[big];
                        shadow_heap[big] = shadow_heap[idx];
                        shadow_heap[idx] = tmp;
                        idx = big;
                    end else begin
                        break;
                    end
                end
            end
        end
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic logic signed [KEY_IN_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(0, 7)) - 4;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_request(logic op, logic signed [KEY_IN_W-1:0] key,
                                logic typed, t_result typed_res);
        t_result res;
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = heap_apply(op, key);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pending();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: check, then pick next ready level
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item: max %0d status %0d count %0d",
                         $time, o_max_value, o_status, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_max_value !== want.max_value) begin
                    n_errors++;
                    $display("%0t: max_value expected %0d actual %0d",
                             $time, want.max_value, o_max_value);
                end
                if (o_status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_count !== want.count) begin
                    n_errors++;
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_count);
                end
            end
        end
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int ph;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIRECTED; k++) begin
            send_request(DIRECTED[k].op, DIRECTED[k].key, DIRECTED[k].typed, DIRECTED[k].res);
        end
        drain_pending();

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph >= N_PHASES - 2) quiet = 1'b1;
            for (k = 0; k < PHASE_LEN; k++) begin
                send_request(($urandom_range(0, 99) < INSERT_PCT[ph]) ? OP_INSERT : OP_REMOVE,
                             random_key(), 1'b0, '0);
            end
            // hold off until the queue is quiet before some phases
            if (ph == 2 || ph == 5) drain_pending();
        end

        drain_pending();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests: %0d inserts, %0d removes; %0d refused full, %0d empty.",
                 n_inserts + n_removes, n_inserts, n_removes, n_full, n_empty);
        $display("Checked %0d results with %0d field errors.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
